// ===== hdl/pidcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pidcs_pkg
// Shared types and constants for the PID controller step unit.
// ----------------------------------------------------------------------------
package pidcs_pkg;

    // one input sample
    typedef struct packed {
        logic signed [31:0] measurement;
        logic signed [31:0] setpoint;
        logic        [15:0] elapsed_ticks;
        logic               auto_mode;
        logic signed [31:0] manual_output;
    } t_in_item;

    // one result
    typedef struct packed {
        logic signed [31:0] drive;
        logic               computed;
    } t_out_item;

    // configuration register set
    typedef struct packed {
        logic        [31:0] prop_gain;
        logic        [31:0] integral_gain;
        logic        [31:0] derivative_gain;
        logic signed [31:0] out_min;
        logic signed [31:0] out_max;
        logic               reverse_direction;
    } t_cfg;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [2:0] REG_OUT_MIN       = 3'd3;
    localparam logic [2:0] REG_OUT_MAX       = 3'd4;
    localparam logic [2:0] REG_REVERSE       = 3'd5;

    localparam logic signed [31:0] OUT_MIN_RESET = -32'sd6553600;
    localparam logic signed [31:0] OUT_MAX_RESET = 32'sd6553600;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_IT,
        OP_MUL_T,
        OP_MUL_D,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_INTEG,
        OP_DRIVE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   emit;
    } t_dp_cmd;

    typedef struct packed {
        logic item_auto;
        logic ticks_zero;
        logic div_last;
    } t_dp_status;

endpackage

// ===== hdl/pid_controller_step_unit.sv =====
// ----------------------------------------------------------------------------
// pid_controller_step_unit
// PID step with derivative on measurement and integral anti-windup.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one sample transaction
// (measurement, setpoint, elapsed ticks, auto flag, manual output).
// Output channel: o_out_valid / i_out_stall carry one result per sample
// (drive, computed flag), held in an output register.
// Manual samples go from the prepare step straight to the final state. Auto
// samples step through the products, the one-bit-per-cycle divider for the
// derivative term, the integral and the drive; samples with zero ticks skip the divider.
// The multiplier is shared over four products.
// The next sample is accepted once the current one has moved into the
// output register; a stalled result keeps the sequencer in its final
// state until the register frees up. Reset clears the integral, last
// measurement and auto flag and loads the default gains (zero) and limits
// (+/-100). The user must write the registers over the APB port only
// while no transaction is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module pid_controller_step_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  pidcs_pkg::t_in_item  i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output pidcs_pkg::t_out_item o_out_item,
    input  logic                 i_out_stall,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import pidcs_pkg::*;

    t_cfg       r_cfg;
    t_dp_cmd    ctrl_cmd;
    t_dp_status dp_status;
    t_out_item  dp_result;
    t_out_item  r_out_item;
    logic       r_out_valid;
    logic       ctrl_busy;
    logic       out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain         <= '0;
            r_cfg.integral_gain     <= '0;
            r_cfg.derivative_gain   <= '0;
            r_cfg.out_min           <= OUT_MIN_RESET;
            r_cfg.out_max           <= OUT_MAX_RESET;
            r_cfg.reverse_direction <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_PROP_GAIN:     r_cfg.prop_gain         <= pwdata;
                REG_INTEGRAL_GAIN: r_cfg.integral_gain     <= pwdata;
                REG_DERIV_GAIN:    r_cfg.derivative_gain   <= pwdata;
                REG_OUT_MIN:       r_cfg.out_min           <= $signed(pwdata);
                REG_OUT_MAX:       r_cfg.out_max           <= $signed(pwdata);
                REG_REVERSE:       r_cfg.reverse_direction <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[4:2])
            REG_PROP_GAIN:     prdata = r_cfg.prop_gain;
            REG_INTEGRAL_GAIN: prdata = r_cfg.integral_gain;
            REG_DERIV_GAIN:    prdata = r_cfg.derivative_gain;
            REG_OUT_MIN:       prdata = r_cfg.out_min;
            REG_OUT_MAX:       prdata = r_cfg.out_max;
            REG_REVERSE:       prdata = {31'd0, r_cfg.reverse_direction};
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // output register
    assign out_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_cmd.emit) begin
            r_out_item <= dp_result;
        end
    end

    pidcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (out_ready),
        .i_status    (dp_status),
        .o_busy      (ctrl_busy),
        .o_cmd       (ctrl_cmd)
    );

    pidcs_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ctrl_cmd),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .o_status (dp_status),
        .o_result (dp_result)
    );

    assign o_in_stall  = ctrl_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // an accepted sample keeps the input side stalled in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // a result is only moved into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrote a pending output");

    // emit happens only while busy, then the sequencer returns to idle
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.emit |-> ctrl_busy ##1 !ctrl_busy)
        else $error("emit outside the final state");

endmodule

// ===== hdl/pidcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidcs_ctrl
// Sequencer: steps the datapath through one sample and hands off the result.
// ----------------------------------------------------------------------------
module pidcs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    input  pidcs_pkg::t_dp_status i_status,
    output logic                  o_busy,
    output pidcs_pkg::t_dp_cmd    o_cmd
);
    import pidcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_MUL_P, S_MUL_I, S_MUL_IT, S_MUL_T, S_MUL_D,
        S_DIV_START, S_DIV, S_INTEG, S_DRIVE, S_DONE
    } t_state;

    t_state r_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:      if (i_in_valid) r_state <= S_PREP;
                S_PREP:      r_state <= i_status.item_auto ? S_MUL_P : S_DONE;
                S_MUL_P:     r_state <= S_MUL_I;
                S_MUL_I:     r_state <= S_MUL_IT;
                S_MUL_IT:    r_state <= S_MUL_T;
                S_MUL_T:     r_state <= S_MUL_D;
                S_MUL_D:     r_state <= i_status.ticks_zero ? S_INTEG : S_DIV_START;
                S_DIV_START: r_state <= S_DIV;
                S_DIV:       if (i_status.div_last) r_state <= S_INTEG;
                S_INTEG:     r_state <= S_DRIVE;
                S_DRIVE:     r_state <= S_DONE;
                S_DONE:      if (i_out_ready) r_state <= S_IDLE;
                default:     r_state <= S_IDLE;
            endcase
        end
    end

    // command decode
    always_comb begin
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_IDLE:      o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_PREP:      o_cmd.op = OP_PREP;
            S_MUL_P:     o_cmd.op = OP_MUL_P;
            S_MUL_I:     o_cmd.op = OP_MUL_I;
            S_MUL_IT:    o_cmd.op = OP_MUL_IT;
            S_MUL_T:     o_cmd.op = OP_MUL_T;
            S_MUL_D:     o_cmd.op = OP_MUL_D;
            S_DIV_START: o_cmd.op = OP_DIV_START;
            S_DIV:       o_cmd.op = OP_DIV_STEP;
            S_INTEG:     o_cmd.op = OP_INTEG;
            S_DRIVE:     o_cmd.op = OP_DRIVE;
            S_DONE: begin
                o_cmd.op   = OP_NONE;
                o_cmd.emit = i_out_ready;
            end
            default:     o_cmd.op = OP_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hdl/pidcs_dp.sv =====
// ----------------------------------------------------------------------------
// pidcs_dp
// Datapath: shared 32x32 multiplier, radix-2 divider, clamps and PID state.
// ----------------------------------------------------------------------------
module pidcs_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pidcs_pkg::t_dp_cmd    i_cmd,
    input  pidcs_pkg::t_in_item   i_item,
    input  pidcs_pkg::t_cfg       i_cfg,
    output pidcs_pkg::t_dp_status o_status,
    output pidcs_pkg::t_out_item  o_result
);
    import pidcs_pkg::*;

    localparam int QW = 64 - FRAC_BITS;     // dividend / quotient width
    localparam int CW = $clog2(QW);

    // clamp to limits, upper limit tested first
    function automatic logic signed [31:0] clamp_lim(
        input logic signed [35:0] v,
        input logic signed [31:0] lo,
        input logic signed [31:0] hi
    );
        logic signed [31:0] res;
        if (v > 36'(hi))      res = hi;
        else if (v < 36'(lo)) res = lo;
        else                  res = v[31:0];
        return res;
    endfunction

    // apply sign to a magnitude no larger than 2^31, saturating
    function automatic logic signed [31:0] sign_sat(
        input logic        neg,
        input logic [31:0] mag
    );
        logic signed [32:0] n;
        logic signed [31:0] res;
        n = -$signed({1'b0, mag});
        if (neg)                     res = n[31:0];
        else if (mag == 32'h8000_0000) res = 32'sh7FFF_FFFF;
        else                         res = $signed(mag);
        return res;
    endfunction

    function automatic logic [31:0] cap31(input logic [63:0] v);
        return (v > 64'h8000_0000) ? 32'h8000_0000 : v[31:0];
    endfunction

    // sample registers
    logic signed [31:0] r_meas, r_setp, r_manual;
    logic        [15:0] r_ticks;
    logic               r_auto;
    // controller state
    logic signed [31:0] r_integ, r_last;
    logic               r_in_auto;
    // working registers
    logic        [31:0] r_emag, r_dmag, r_imag;
    logic               r_eneg, r_dneg;
    logic        [63:0] r_prod;
    logic signed [32:0] r_p, r_d;
    logic signed [31:0] r_inc;
    logic        [QW-1:0] r_quo;
    logic        [15:0] r_rem;
    logic        [CW-1:0] r_cnt;
    logic signed [31:0] r_drive;
    logic               r_computed;

    logic signed [32:0] err, dm;
    logic        [63:0] prod_sh;
    logic        [16:0] rem_sh;
    logic               q_bit;
    logic signed [31:0] d_term;
    logic signed [32:0] p_rev, inc_rev, d_rev;
    logic signed [35:0] integ_sum, drive_sum;
    logic        [31:0] mul_a, mul_b;

    // error and measurement change
    assign err = 33'(r_setp) - 33'(r_meas);
    assign dm  = 33'(r_meas) - 33'(r_in_auto ? r_last : r_meas);

    // shared multiplier operand select
    always_comb begin
        unique case (i_cmd.op)
            OP_MUL_P: begin mul_a = r_emag; mul_b = i_cfg.prop_gain;       end
            OP_MUL_I: begin mul_a = r_emag; mul_b = i_cfg.integral_gain;   end
            OP_MUL_T: begin mul_a = r_imag; mul_b = 32'(r_ticks);          end
            OP_MUL_D: begin mul_a = r_dmag; mul_b = i_cfg.derivative_gain; end
            default:  begin mul_a = r_emag; mul_b = i_cfg.prop_gain;       end
        endcase
    end

    assign prod_sh = r_prod >> FRAC_BITS;

    // divider step
    assign rem_sh = {r_rem, r_quo[QW-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_ticks});

    // sign, direction and sums
    assign d_term    = r_ticks == 16'd0 ? 32'sd0 : sign_sat(r_dneg, cap31(64'(r_quo)));
    assign p_rev     = i_cfg.reverse_direction ? -r_p : r_p;
    assign inc_rev   = i_cfg.reverse_direction ? -33'(r_inc) : 33'(r_inc);
    assign d_rev     = i_cfg.reverse_direction ? -33'(d_term) : 33'(d_term);
    assign integ_sum = 36'(r_integ) + 36'(inc_rev);
    assign drive_sum = 36'(r_p) + 36'(r_integ) - 36'(r_d);

    // PID state, reset cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ   <= '0;
            r_last    <= '0;
            r_in_auto <= 1'b0;
        end else begin
            if (i_cmd.op == OP_PREP) begin
                if (!r_auto) begin
                    r_in_auto <= 1'b0;
                end else if (!r_in_auto) begin
                    r_integ   <= clamp_lim(36'(r_manual), i_cfg.out_min, i_cfg.out_max);
                    r_in_auto <= 1'b1;
                end
            end
            if (i_cmd.op == OP_INTEG) begin
                r_integ <= clamp_lim(integ_sum, i_cfg.out_min, i_cfg.out_max);
                r_last  <= r_meas;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_meas   <= i_item.measurement;
                r_setp   <= i_item.setpoint;
                r_ticks  <= i_item.elapsed_ticks;
                r_auto   <= i_item.auto_mode;
                r_manual <= i_item.manual_output;
            end
            OP_PREP: begin
                r_eneg     <= err[32];
                r_emag     <= err[32] ? 32'(-err) : err[31:0];
                r_dneg     <= dm[32];
                r_dmag     <= dm[32] ? 32'(-dm) : dm[31:0];
                r_drive    <= r_manual;
                r_computed <= 1'b0;
            end
            OP_MUL_P: r_prod <= mul_a * mul_b;
            OP_MUL_I: begin
                r_p    <= 33'(sign_sat(r_eneg, cap31(prod_sh)));
                r_prod <= mul_a * mul_b;
            end
            OP_MUL_IT: r_imag <= cap31(prod_sh);
            OP_MUL_T:  r_prod <= mul_a * mul_b;
            OP_MUL_D: begin
                r_inc  <= sign_sat(r_eneg, cap31(r_prod));
                r_prod <= mul_a * mul_b;
            end
            OP_DIV_START: begin
                r_quo <= prod_sh[QW-1:0];
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= q_bit ? 16'(rem_sh - {1'b0, r_ticks}) : rem_sh[15:0];
                r_quo <= {r_quo[QW-2:0], q_bit};
                r_cnt <= r_cnt + 1'b1;
            end
            OP_INTEG: begin
                r_p <= p_rev;
                r_d <= d_rev;
            end
            OP_DRIVE: begin
                r_drive    <= clamp_lim(drive_sum, i_cfg.out_min, i_cfg.out_max);
                r_computed <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_status.item_auto  = r_auto;
    assign o_status.ticks_zero = (r_ticks == 16'd0);
    assign o_status.div_last   = (r_cnt == CW'(QW - 1));

    assign o_result.drive    = r_drive;
    assign o_result.computed = r_computed;

endmodule

// ===== tb/sv/tb_pid_controller_step_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_controller_step_unit
// Self-checking bench for the PID step unit: a directed sample table and
// randomized sample streams run under several register settings. Every result
// transaction is checked field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_pid_controller_step_unit;
    import pidcs_pkg::*;

    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_item = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pid_controller_step_unit #(.FRAC_BITS(FRAC)) dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of registers and controller state
    logic [31:0]        kp, ki, kd;
    logic signed [63:0] lim_lo, lim_hi;
    logic               rev;
    logic signed [63:0] integ, prev_meas;
    logic               was_auto;

    t_out_item drive_queue[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  auto_seen = 0;
    int  cycles = 0;
    bit  pace_free = 1'b0;   // no idling on either side
    bit  hold_off = 1'b0;    // long receiver stall

    function automatic logic signed [63:0] lim_clamp(logic signed [63:0] v);
        if (v > lim_hi) return lim_hi;
        if (v < lim_lo) return lim_lo;
        return v;
    endfunction

    function automatic logic signed [63:0] sign_sat(bit neg, logic [63:0] mag);
        logic signed [63:0] v;
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        v = neg ? -$signed(mag) : $signed(mag);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        return v;
    endfunction

    // compute the expected result of one sample and advance the state
    function automatic t_out_item pid_step(t_in_item s);
        t_out_item r;
        logic signed [63:0] meas, err, p, inc, dm, d, drv;
        logic [63:0] emag, imag, dmag, tk;
        meas = s.measurement;
        tk = s.elapsed_ticks;
        if (!s.auto_mode) begin
            was_auto = 1'b0;
            r.drive = s.manual_output;
            r.computed = 1'b0;
            return r;
        end
        // bumpless transfer on manual to auto
        if (!was_auto) begin
            integ = lim_clamp(s.manual_output);
            prev_meas = meas;
            was_auto = 1'b1;
        end
        err = s.setpoint - meas;
        emag = err < 0 ? -err : err;
        p = sign_sat(err < 0, (emag * kp) >> FRAC);
        imag = (emag * ki) >> FRAC;
        if (imag > 64'h8000_0000) imag = 64'h8000_0000;
        inc = sign_sat(err < 0, imag * tk);
        dm = meas - prev_meas;
        d = 0;
        if (tk != 0) begin
            dmag = ((dm < 0 ? -dm : dm) * kd) >> FRAC;
            d = sign_sat(dm < 0, dmag / tk);
        end
        if (rev) begin
            p = -p;
            inc = -inc;
            d = -d;
        end
        integ = lim_clamp(integ + inc);
        drv = lim_clamp(p + integ - d);
        prev_meas = meas;
        r.drive = drv[31:0];
        r.computed = 1'b1;
        return r;
    endfunction

    // sender idling; valid drops only while idling
    task automatic pace_wait();
        if (!pace_free)
            while ($urandom_range(99) < 29) begin
                if (i_in_valid) i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
    endtask

    // one sample transaction; expectation queued at acceptance
    task automatic send_sample(input t_in_item s);
        pace_wait();
        i_in_valid <= 1'b1;
        i_in_item <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        drive_queue.push_back(pid_step(s));
    endtask

    task automatic wait_idle();
        if (i_in_valid) i_in_valid <= 1'b0;
        while (drive_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_PROP_GAIN:     kp = val;
            REG_INTEGRAL_GAIN: ki = val;
            REG_DERIV_GAIN:    kd = val;
            REG_OUT_MIN:       lim_lo = $signed(val);
            REG_OUT_MAX:       lim_hi = $signed(val);
            REG_REVERSE:       rev = val[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] p, i, d, lo, hi, input bit r);
        wait_idle();
        reg_write(REG_PROP_GAIN, p);
        reg_write(REG_INTEGRAL_GAIN, i);
        reg_write(REG_DERIV_GAIN, d);
        reg_write(REG_OUT_MIN, lo);
        reg_write(REG_OUT_MAX, hi);
        reg_write(REG_REVERSE, {31'b0, r});
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return $urandom_range(2000) - 1000;
            3: return ($urandom_range(400) - 200) << FRAC;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item rnd_sample(bit mostly_auto);
        t_in_item s;
        s.measurement = rnd_val();
        s.setpoint = ($urandom_range(3) == 0) ? s.measurement + $urandom_range(65536)
                                              : rnd_val();
        case ($urandom_range(4))
            0: s.elapsed_ticks = 16'd0;
            1: s.elapsed_ticks = 16'hFFFF - $urandom_range(1);
            2: s.elapsed_ticks = $urandom;
            default: s.elapsed_ticks = $urandom_range(1, 20);
        endcase
        s.auto_mode = mostly_auto ? ($urandom_range(9) != 0) : $urandom_range(1);
        s.manual_output = rnd_val();
        return s;
    endfunction

    // directed table; expected drive typed only where obvious
    typedef struct {
        t_in_item s;
        bit       typed;
        t_out_item r;
    } t_row;

    // receiver: stall pacing plus result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (drive_queue.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected result drive=%0d", o_out_item.drive);
            end else begin
                t_out_item e;
                e = drive_queue.pop_front();
                if (e.computed) auto_seen <= auto_seen + 1;
                if (e.drive !== o_out_item.drive || e.computed !== o_out_item.computed) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: exp drive=%0d computed=%0b got drive=%0d computed=%0b",
                                 e.drive, e.computed, o_out_item.drive, o_out_item.computed);
                end
            end
        end
        i_out_stall <= hold_off || (!pace_free && $urandom_range(99) < 29);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("pid_controller_step_unit verification failed");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        t_in_item s;
        int n;
        kp = 0; ki = 0; kd = 0; rev = 1'b0;
        lim_lo = OUT_MIN_RESET; lim_hi = OUT_MAX_RESET;
        integ = 0; prev_meas = 0; was_auto = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: zero gains, so auto drive is the clamped manual output
        row.typed = 1'b1;
        row.s = '{32'sd0, 32'sd0, 16'd0, 1'b0, 32'sh8000_0000};
        row.r = '{32'sh8000_0000, 1'b0}; rows.push_back(row);
        row.s = '{32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 1'b0, 32'sh7FFF_FFFF};
        row.r = '{32'sh7FFF_FFFF, 1'b0}; rows.push_back(row);
        row.s = '{32'sd5, 32'sd9, 16'd3, 1'b1, 32'sh7FFF_FFFF};
        row.r = '{OUT_MAX_RESET, 1'b1}; rows.push_back(row);
        row.s = '{32'sd0, 32'sd0, 16'd0, 1'b0, 32'sh8000_0000};
        row.r = '{32'sh8000_0000, 1'b0}; rows.push_back(row);
        row.s = '{32'sd0, 32'sd0, 16'd0, 1'b1, 32'sh8000_0000};
        row.r = '{OUT_MIN_RESET, 1'b1}; rows.push_back(row);
        foreach (rows[k]) begin
            send_sample(rows[k].s);
            if (rows[k].typed && rows[k].r !== drive_queue[$]) begin
                mismatches++;
                $display("directed row %0d: table disagrees with predictor", k);
            end
        end

        // extremes: full gains, extreme fields, zero ticks, reverse
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        rows.delete();
        row.typed = 1'b0;
        row.s = '{32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF, 1'b1, 32'sd0}; rows.push_back(row);
        row.s = '{32'sh7FFF_FFFF, 32'sh8000_0000, 16'd1, 1'b1, 32'sd0};    rows.push_back(row);
        row.s = '{32'sh8000_0000, 32'sh8000_0000, 16'd0, 1'b1, 32'sd0};    rows.push_back(row);
        row.s = '{32'sd65536, 32'sd0, 16'd7, 1'b1, 32'sd0};                rows.push_back(row);
        row.s = '{32'sd0, 32'sd65536, 16'd0, 1'b0, 32'sd123};              rows.push_back(row);
        foreach (rows[k]) send_sample(rows[k].s);
        wait_idle();
        reg_write(REG_REVERSE, 32'd1);
        foreach (rows[k]) send_sample(rows[k].s);

        // inverted limits
        set_regs(32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
                 32'h0064_0000, 32'hFF9C_0000, 1'b0);
        foreach (rows[k]) send_sample(rows[k].s);

        // random phases under varied settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_regs(32'h0001_0000, 32'h0000_0100, 32'h0000_4000,
                            OUT_MIN_RESET, OUT_MAX_RESET, 1'b0);
                1: set_regs(32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
                7: set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
                default: set_regs($urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 18),
                                  $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 14),
                                  $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 18),
                                  rnd_val(), rnd_val(), $urandom_range(1));
            endcase
            pace_free = (ph == 3);
            n = 0;
            // hold off the receiver so the unit backs up its input
            if (ph == 5)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            while (n < 175) begin
                s = rnd_sample(ph != 1);
                send_sample(s);
                n++;
            end
            // sender pauses until all results are back
            if (ph == 4) wait_idle();
        end

        wait_idle();
        $display("covered %0d results (%0d computed) over directed extremes and 8 random phases",
                 results_seen, auto_seen);
        if (mismatches == 0 && drive_queue.size() == 0) begin
            $display("pid_controller_step_unit verification clean");
        end else begin
            $display("%0d mismatches, %0d expectations left", mismatches, drive_queue.size());
            $display("pid_controller_step_unit verification failed");
        end
        $finish;
    end
endmodule
